// ===== design/text_terminal_cursor_scroll_unit_defines.svh =====
// ----------------------------------------------------------------------------
// text terminal cursor scroll unit: assertion macros
// concurrent assertion shorthands clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_UNIT_DEFINES_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_UNIT_DEFINES_SVH

// plain property check
`define TTCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define TTCS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define TTCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ttcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcs_pkg
// shared constants, controller states and controller/datapath signal groups
// ----------------------------------------------------------------------------
package ttcs_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
	localparam logic [CELL_W-1:0] ZERO_CELL    = 16'h0000;
	localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'h07;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_CLEAR
	} ctrl_state_t;

	typedef struct packed {
		logic init_en;
		logic accept_put;
		logic accept_read;
		logic clear_en;
		logic ld_read;
		logic ld_scroll;
	} dp_cmd_t;

	typedef struct packed {
		logic init_last;
		logic clear_last;
		logic put_scrolls;
	} dp_sts_t;

endpackage

// ===== design/ttcs_ifs.sv =====
// ----------------------------------------------------------------------------
// ttcs channel interfaces
// request, response and attribute write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ttcs_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [ttcs_pkg::CHAR_W-1:0] char_code;
	logic [ttcs_pkg::ROW_W-1:0]  read_row;
	logic [ttcs_pkg::COL_W-1:0]  read_col;

	modport source (output valid, op, char_code, read_row, read_col, input ready);
	modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

interface ttcs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ttcs_pkg::CELL_W-1:0] cell_data;
	logic [ttcs_pkg::ROW_W-1:0]  cursor_row_out;
	logic [ttcs_pkg::COL_W-1:0]  cursor_col_out;
	logic                        scrolled;

	modport source (output valid, cell_data, cursor_row_out, cursor_col_out, scrolled,
		input ready);
	modport sink   (input valid, cell_data, cursor_row_out, cursor_col_out, scrolled,
		output ready);
endinterface

interface ttcs_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [ttcs_pkg::CHAR_W-1:0] text_color;

	modport source (output valid, text_color, input ready);
	modport sink   (input valid, text_color, output ready);
endinterface

// ===== design/ttcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttcs_ctrl
// sequencer: init sweep, request acceptance, read wait, row clear, output valid
// ----------------------------------------------------------------------------
module ttcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_op,
	output logic              cmd_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  ttcs_pkg::dp_sts_t sts,
	output ttcs_pkg::dp_cmd_t cmd
);

	ttcs_pkg::ctrl_state_t state_q;
	ttcs_pkg::ctrl_state_t state_nxt;
	logic                  out_valid_q;
	logic                  out_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ttcs_pkg::ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			ttcs_pkg::ST_INIT: begin
				cmd.init_en = 1'b1;
				if (sts.init_last) begin
					state_nxt = ttcs_pkg::ST_IDLE;
				end
			end
			ttcs_pkg::ST_IDLE: begin
				cmd_ready = !out_valid_q || rsp_ready;
				if (cmd_valid && cmd_ready) begin
					if (cmd_op == ttcs_pkg::OP_READ) begin
						cmd.accept_read = 1'b1;
						state_nxt       = ttcs_pkg::ST_READ;
					end else begin
						cmd.accept_put = 1'b1;
						if (sts.put_scrolls) begin
							state_nxt = ttcs_pkg::ST_CLEAR;
						end
					end
				end
			end
			ttcs_pkg::ST_READ: begin
				cmd.ld_read = 1'b1;
				state_nxt   = ttcs_pkg::ST_IDLE;
			end
			ttcs_pkg::ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					cmd.ld_scroll = 1'b1;
					state_nxt     = ttcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = ttcs_pkg::ST_INIT;
			end
		endcase
	end

	assign out_set   = cmd.ld_read || cmd.ld_scroll || (cmd.accept_put && !sts.put_scrolls);
	assign rsp_valid = out_valid_q;

endmodule

// ===== design/ttcs_datapath.sv =====
// ----------------------------------------------------------------------------
// ttcs_datapath
// screen memory with circular row base, cursor, attribute and output registers
// ----------------------------------------------------------------------------
module ttcs_datapath #(
	parameter int COLUMNS = ttcs_pkg::COLUMNS_DEF,
	parameter int ROWS    = ttcs_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ttcs_pkg::dp_cmd_t           cmd,
	output ttcs_pkg::dp_sts_t           sts,
	input  logic                        cfg_we,
	input  logic [ttcs_pkg::CHAR_W-1:0] cfg_color,
	input  logic [ttcs_pkg::CHAR_W-1:0] char_code,
	input  logic [ttcs_pkg::ROW_W-1:0]  read_row,
	input  logic [ttcs_pkg::COL_W-1:0]  read_col,
	output logic [ttcs_pkg::CELL_W-1:0] cell_data,
	output logic [ttcs_pkg::ROW_W-1:0]  cursor_row_out,
	output logic [ttcs_pkg::COL_W-1:0]  cursor_col_out,
	output logic                        scrolled
);

	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = ttcs_pkg::ROW_W;
	localparam int CW    = ttcs_pkg::COL_W;

	logic [ttcs_pkg::CELL_W-1:0] mem [DEPTH];

	logic [RW-1:0]               cur_row_q;
	logic [CW-1:0]               cur_col_q;
	logic [RW-1:0]               top_q;
	logic [ttcs_pkg::CHAR_W-1:0] color_q;
	logic [AW-1:0]               init_cnt_q;
	logic [RW-1:0]               clr_row_q;
	logic [CW-1:0]               clr_col_q;
	logic [ttcs_pkg::CELL_W-1:0] rdata_q;
	logic                        oor_q;

	logic [ttcs_pkg::CELL_W-1:0] out_data_q;
	logic [RW-1:0]               out_row_q;
	logic [CW-1:0]               out_col_q;
	logic                        out_scr_q;

	logic                        is_nl;
	logic                        row_adv;
	logic                        scroll;
	logic [RW-1:0]               row_nxt;
	logic [CW-1:0]               col_nxt;
	logic [RW-1:0]               top_nxt;
	logic                        rd_in_range;
	logic [AW-1:0]               put_addr;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               clr_addr;
	logic                        we;
	logic [AW-1:0]               waddr;
	logic [ttcs_pkg::CELL_W-1:0] wdata;

	// logical row to physical row through the circular base
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
		input logic [RW-1:0] row);
		logic [RW:0] sum;
		sum = {1'b0, base} + {1'b0, row};
		if (sum >= (RW+1)'(ROWS)) begin
			sum = sum - (RW+1)'(ROWS);
		end
		return sum[RW-1:0];
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
		input logic [CW-1:0] col);
		return AW'(prow) * AW'(COLUMNS) + AW'(col);
	endfunction

	// put decode
	assign is_nl   = (char_code == ttcs_pkg::NEWLINE_CODE);
	assign row_adv = is_nl || (cur_col_q == CW'(COLUMNS - 1));
	assign scroll  = row_adv && (cur_row_q == RW'(ROWS - 1));
	assign col_nxt = row_adv ? '0 : cur_col_q + CW'(1);
	assign row_nxt = (row_adv && !scroll) ? cur_row_q + RW'(1) : cur_row_q;
	assign top_nxt = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);

	assign rd_in_range = ({1'b0, read_row} < (RW+1)'(ROWS))
		&& ({1'b0, read_col} < (CW+1)'(COLUMNS));

	assign put_addr = cell_addr(phys_row(top_q, cur_row_q), cur_col_q);
	assign rd_addr  = cell_addr(phys_row(top_q, read_row), read_col);
	assign clr_addr = cell_addr(clr_row_q, clr_col_q);

	assign sts.init_last   = (init_cnt_q == AW'(DEPTH - 1));
	assign sts.clear_last  = (clr_col_q == CW'(COLUMNS - 1));
	assign sts.put_scrolls = scroll;

	// single write port
	always_comb begin
		we    = 1'b0;
		waddr = put_addr;
		wdata = {color_q, char_code};
		if (cmd.init_en) begin
			we    = 1'b1;
			waddr = init_cnt_q;
			wdata = ttcs_pkg::BLANK_CELL;
		end else if (cmd.clear_en) begin
			we    = 1'b1;
			waddr = clr_addr;
			wdata = ttcs_pkg::ZERO_CELL;
		end else if (cmd.accept_put && !is_nl) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_read) begin
			rdata_q <= mem[rd_addr];
			oor_q   <= !rd_in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			top_q      <= '0;
			color_q    <= ttcs_pkg::COLOR_RESET;
			init_cnt_q <= '0;
			clr_row_q  <= '0;
			clr_col_q  <= '0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_color;
			end
			if (cmd.init_en) begin
				init_cnt_q <= init_cnt_q + AW'(1);
			end
			if (cmd.accept_put) begin
				cur_row_q <= row_nxt;
				cur_col_q <= col_nxt;
				if (scroll) begin
					top_q     <= top_nxt;
					clr_row_q <= top_q;
					clr_col_q <= '0;
				end
			end else if (cmd.clear_en) begin
				clr_col_q <= clr_col_q + CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.accept_put && !scroll) begin
			out_data_q <= ttcs_pkg::ZERO_CELL;
			out_row_q  <= row_nxt;
			out_col_q  <= col_nxt;
			out_scr_q  <= 1'b0;
		end else if (cmd.ld_read) begin
			out_data_q <= oor_q ? ttcs_pkg::ZERO_CELL : rdata_q;
			out_row_q  <= cur_row_q;
			out_col_q  <= cur_col_q;
			out_scr_q  <= 1'b0;
		end else if (cmd.ld_scroll) begin
			out_data_q <= ttcs_pkg::ZERO_CELL;
			out_row_q  <= cur_row_q;
			out_col_q  <= cur_col_q;
			out_scr_q  <= 1'b1;
		end
	end

	assign cell_data      = out_data_q;
	assign cursor_row_out = out_row_q;
	assign cursor_col_out = out_col_q;
	assign scrolled       = out_scr_q;

endmodule

// ===== design/text_terminal_cursor_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_unit
// character-cell text terminal with cursor, line wrap and scroll
// ----------------------------------------------------------------------------
// channels: cmd takes one request (put a character or read one cell), rsp
// returns exactly one result per request, cfg writes the attribute byte used
// for new cells at any time (always ready).
// results are registered: a put loads its result on acceptance, a read first
// registers the cell and then loads it, and a scrolling put loads it after
// the row clear. scroll is a move of the circular top-row base plus a clear
// of the new bottom row, one cell per cycle through the single memory write
// port; that sweep sets the slow case. cmd takes no request during the read or the clear.
// reset: cursor to the top left, attribute to 0x07, then a fill pass writes
// spaces in grey on black to all ROWS * COLUMNS cells; cmd is not ready
// during that pass.
// stall: the result sits in an output register; a new request is taken in the
// cycle the pending result is taken, and cmd holds off while rsp is stalled.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_unit #(
	parameter int COLUMNS = ttcs_pkg::COLUMNS_DEF,
	parameter int ROWS    = ttcs_pkg::ROWS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	ttcs_cmd_if.sink   cmd,
	ttcs_rsp_if.source rsp,
	ttcs_cfg_if.sink   cfg
);

	ttcs_pkg::dp_cmd_t dp_cmd;
	ttcs_pkg::dp_sts_t dp_sts;

	assign cfg.ready = 1'b1;

	ttcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_op    (cmd.op),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	ttcs_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.sts            (dp_sts),
		.cfg_we         (cfg.valid),
		.cfg_color      (cfg.text_color),
		.char_code      (cmd.char_code),
		.read_row       (cmd.read_row),
		.read_col       (cmd.read_col),
		.cell_data      (rsp.cell_data),
		.cursor_row_out (rsp.cursor_row_out),
		.cursor_col_out (rsp.cursor_col_out),
		.scrolled       (rsp.scrolled)
	);

endmodule

// ===== design/ttcs_checker.sv =====
// ----------------------------------------------------------------------------
// ttcs_checker
// port-level checks on cursor results and request/result ordering
// ----------------------------------------------------------------------------
`include "text_terminal_cursor_scroll_unit_defines.svh"

module ttcs_checker #(
	parameter int COLUMNS = ttcs_pkg::COLUMNS_DEF,
	parameter int ROWS    = ttcs_pkg::ROWS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [ttcs_pkg::CELL_W-1:0] rsp_cell_data,
	input logic [ttcs_pkg::ROW_W-1:0]  rsp_row,
	input logic [ttcs_pkg::COL_W-1:0]  rsp_col,
	input logic                        rsp_scrolled
);

	`TTCS_ASSERT_IMPL(a_cursor_range, rsp_valid, ({1'b0, rsp_col} < (ttcs_pkg::COL_W+1)'(COLUMNS)) && ({1'b0, rsp_row} < (ttcs_pkg::ROW_W+1)'(ROWS)), "cursor out of screen")
	`TTCS_ASSERT_IMPL(a_scroll_pos, rsp_valid && rsp_scrolled, (rsp_row == ttcs_pkg::ROW_W'(ROWS - 1)) && (rsp_col == '0) && (rsp_cell_data == '0), "scroll result not at bottom row start")
	`TTCS_ASSERT_IMPL(a_one_in_flight, cmd_valid && cmd_ready, !rsp_valid || rsp_ready, "request taken while result stalled")
	`TTCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cell_data) && $stable(rsp_row) && $stable(rsp_col) && $stable(rsp_scrolled), "stalled result changed")

endmodule

bind text_terminal_cursor_scroll_unit ttcs_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_ttcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_cell_data (rsp.cell_data),
	.rsp_row       (rsp.cursor_row_out),
	.rsp_col       (rsp.cursor_col_out),
	.rsp_scrolled  (rsp.scrolled)
);
